// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// expects signals named clock and reset in the scope of use
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define PSV_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/psv_pkg.sv =====
// ---------------------------------------------------------------------------
// psv_pkg: shared types, constants and table functions
// widths of the slice request and vertex fields, sine table content
// ---------------------------------------------------------------------------
package psv_pkg;

   localparam int LINE_COUNT_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;

   localparam int PIXEL_W    = 16;
   localparam int RADIUS_W   = 16;
   localparam int ANGLE_W    = 17;
   localparam int COORD_W    = 21;
   localparam int MAG_W      = 15;
   localparam int FRAC_BITS  = 4;
   localparam int TRIG_FRAC  = 14;
   localparam int TPROD_W    = RADIUS_W + MAG_W;

   localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(65536);

   typedef struct packed {
      logic signed [PIXEL_W-1:0] center_x;
      logic signed [PIXEL_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
      logic [ANGLE_W-1:0]        start_angle;
      logic [ANGLE_W-1:0]        end_angle;
      logic                      fill_on;
   } req_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] center_x;
      logic signed [PIXEL_W-1:0] center_y;
      logic [RADIUS_W-1:0]       radius;
   } job_type;

   typedef struct packed {
      logic               center;
      logic               last;
      logic [ANGLE_W-1:0] angle;
   } vtx_desc_type;

   typedef struct packed {
      logic [MAG_W-1:0] sin_mag;
      logic             sin_neg;
      logic [MAG_W-1:0] cos_mag;
      logic             cos_neg;
   } trig_type;

   // quarter-wave sine entry in q14, taylor series to the x^13 term
   function automatic logic [MAG_W-1:0] sine_entry(int unsigned k, int unsigned bits);
      logic [63:0] x;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      x    = (64'd1686629713 * 64'(k)) >> bits;
      term = x;
      sum  = longint'(x);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((((term * x) >> 30) * x) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) + 64'd32768) >> 16;
      if (v > 64'd16384) begin
         v = 64'd16384;
      end
      if (k == (32'd1 << bits)) begin
         v = 64'd16384;
      end
      return MAG_W'(v);
   endfunction

endpackage

// ===== hw/rtl/psv_req_if.sv =====
// ---------------------------------------------------------------------------
// psv_req_if: slice request channel
// valid/ready handshake with one slice description per beat
// ---------------------------------------------------------------------------
interface psv_req_if import psv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [PIXEL_W-1:0] center_x;
   logic signed [PIXEL_W-1:0] center_y;
   logic [RADIUS_W-1:0]       radius;
   logic [ANGLE_W-1:0]        start_angle;
   logic [ANGLE_W-1:0]        end_angle;
   logic                      fill_on;

   modport source (
      output valid, center_x, center_y, radius, start_angle, end_angle, fill_on,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, radius, start_angle, end_angle, fill_on,
      output ready
   );
endinterface

// ===== hw/rtl/psv_rsp_if.sv =====
// ---------------------------------------------------------------------------
// psv_rsp_if: vertex result channel
// valid/ready handshake with one vertex per beat
// ---------------------------------------------------------------------------
interface psv_rsp_if import psv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] vertex_x;
   logic signed [COORD_W-1:0] vertex_y;
   logic                      at_center;
   logic                      last_vertex;

   modport source (
      output valid, vertex_x, vertex_y, at_center, last_vertex,
      input  ready
   );
   modport sink (
      input  valid, vertex_x, vertex_y, at_center, last_vertex,
      output ready
   );
endinterface

// ===== hw/rtl/pie_slice_vertex_generator.sv =====
// ---------------------------------------------------------------------------
// pie_slice_vertex_generator: arc fan vertex list from one slice request
// first vertex passes the sequencer state, stage a, stage b and the output register,
// then one vertex a cycle while the output is not stalled; a slice of N vertices
// (N <= 2*LINE_COUNT+3) drains the ram read and multiply before the next request beat
// reset: clears control, then writes the sine ram; requests wait through the fill cycles
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pie_slice_vertex_generator import psv_pkg::*; #(
   parameter int LINE_COUNT      = LINE_COUNT_DEF,
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   psv_req_if.sink  req_if,
   psv_rsp_if.source rsp_if
);

   req_type      req;
   job_type      job;
   vtx_desc_type desc;
   trig_type     trig;
   logic         desc_valid;
   logic         seq_ready;
   logic         table_ready;
   logic         adv;
   logic         open;

   // stage a: ram read in flight
   logic a_valid_ff, a_valid_in;
   logic a_center_ff;
   logic a_last_ff;

   // stage b: products
   logic               b_valid_ff, b_valid_in;
   logic               b_center_ff;
   logic               b_last_ff;
   logic               b_sin_neg_ff;
   logic               b_cos_neg_ff;
   logic [TPROD_W-1:0] b_sin_prod_ff;
   logic [TPROD_W-1:0] b_cos_prod_ff;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   logic                      out_center_ff;
   logic                      out_last_ff;

   logic [TPROD_W-1:0]        sin_rnd;
   logic [TPROD_W-1:0]        cos_rnd;
   logic signed [COORD_W-1:0] sin_m;
   logic signed [COORD_W-1:0] cos_m;
   logic signed [COORD_W-1:0] cx16;
   logic signed [COORD_W-1:0] cy16;

   assign req.center_x    = req_if.center_x;
   assign req.center_y    = req_if.center_y;
   assign req.radius      = req_if.radius;
   assign req.start_angle = req_if.start_angle;
   assign req.end_angle   = req_if.end_angle;
   assign req.fill_on     = req_if.fill_on;
   assign req_if.ready    = seq_ready;

   assign adv  = !out_valid_ff || rsp_if.ready;
   // held center and radius stay in use until stages a and b drain
   assign open = table_ready && !a_valid_ff && !b_valid_ff;

   psv_sequencer #(
      .LINE_COUNT (LINE_COUNT)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .open       (open),
      .req_valid  (req_if.valid),
      .req_ready  (seq_ready),
      .req        (req),
      .step       (adv),
      .desc_valid (desc_valid),
      .desc       (desc),
      .job        (job)
   );

   psv_sine_unit #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine (
      .clock       (clock),
      .reset       (reset),
      .lookup_en   (adv),
      .angle       (desc.angle),
      .trig        (trig),
      .table_ready (table_ready)
   );

   always_comb begin
      a_valid_in   = adv ? desc_valid : a_valid_ff;
      b_valid_in   = adv ? a_valid_ff : b_valid_ff;
      out_valid_in = adv ? b_valid_ff : out_valid_ff;
   end

   // round half away from zero on the magnitude, sign applied after
   always_comb begin
      sin_rnd = b_sin_prod_ff + TPROD_W'(8192);
      cos_rnd = b_cos_prod_ff + TPROD_W'(8192);
      sin_m   = signed'(COORD_W'(sin_rnd >> TRIG_FRAC));
      cos_m   = signed'(COORD_W'(cos_rnd >> TRIG_FRAC));
      cx16    = signed'({{(COORD_W - PIXEL_W - FRAC_BITS){job.center_x[PIXEL_W-1]}},
                         job.center_x, {FRAC_BITS{1'b0}}});
      cy16    = signed'({{(COORD_W - PIXEL_W - FRAC_BITS){job.center_y[PIXEL_W-1]}},
                         job.center_y, {FRAC_BITS{1'b0}}});
      if (b_center_ff) begin
         out_x_in = cx16;
         out_y_in = cy16;
      end else begin
         out_x_in = b_cos_neg_ff ? cx16 - cos_m : cx16 + cos_m;
         out_y_in = b_sin_neg_ff ? cy16 + sin_m : cy16 - sin_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_center_ff   <= desc.center;
         a_last_ff     <= desc.last;
         b_center_ff   <= a_center_ff;
         b_last_ff     <= a_last_ff;
         b_sin_neg_ff  <= trig.sin_neg;
         b_cos_neg_ff  <= trig.cos_neg;
         b_sin_prod_ff <= TPROD_W'(job.radius) * TPROD_W'(trig.sin_mag);
         b_cos_prod_ff <= TPROD_W'(job.radius) * TPROD_W'(trig.cos_mag);
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_center_ff <= b_center_ff;
         out_last_ff   <= b_last_ff;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.vertex_x    = out_x_ff;
   assign rsp_if.vertex_y    = out_y_ff;
   assign rsp_if.at_center   = out_center_ff;
   assign rsp_if.last_vertex = out_last_ff;

   `PSV_ASSERT_IMP(a_fill_blocks_req, !table_ready, !req_if.ready)
   `PSV_ASSERT_NXT(a_stall_holds_b, b_valid_ff && !adv, b_valid_ff)
   `PSV_ASSERT_IMP(a_last_drains, rsp_if.valid && rsp_if.ready && rsp_if.last_vertex,
                   !a_valid_ff && !b_valid_ff)

endmodule

// ===== hw/rtl/psv_ram.sv =====
// ---------------------------------------------------------------------------
// psv_ram: generic synchronous ram
// one write port, two read ports with registered data and read enable
// ---------------------------------------------------------------------------
module psv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hw/rtl/psv_sine_unit.sv =====
// ---------------------------------------------------------------------------
// psv_sine_unit: sine and cosine lookup from a quarter-wave table in ram
// fills the ram after reset, then folds an angle into two table reads
// ---------------------------------------------------------------------------
module psv_sine_unit import psv_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               lookup_en,
   input  logic [ANGLE_W-1:0] angle,
   output trig_type           trig,
   output logic               table_ready
);

   localparam int QUARTER = 1 << SINE_TABLE_BITS;
   localparam int DEPTH   = QUARTER + 1;
   localparam int AW      = SINE_TABLE_BITS + 1;
   localparam int PW      = SINE_TABLE_BITS + 2;
   localparam int SHIFT   = 14 - SINE_TABLE_BITS;
   localparam int HALF    = (1 << SHIFT) >> 1;

   logic [MAG_W-1:0] sine_tab [DEPTH];
   logic [AW-1:0]    fill_addr_ff;
   logic [AW-1:0]    fill_addr_in;
   logic             fill_done_ff;
   logic             fill_done_in;
   logic             sin_neg_ff;
   logic             cos_neg_ff;
   logic [ANGLE_W:0] rounded;
   logic [PW-1:0]    p_sin;
   logic [PW-1:0]    p_cos;
   logic [AW-1:0]    addr_sin;
   logic [AW-1:0]    addr_cos;
   logic [MAG_W-1:0] sin_mag;
   logic [MAG_W-1:0] cos_mag;

   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      assign sine_tab[k] = sine_entry(k, SINE_TABLE_BITS);
   end

   // odd quadrants read the table backwards
   function automatic logic [AW-1:0] fold(logic [PW-1:0] p);
      logic [AW-1:0] r;
      r = {1'b0, p[SINE_TABLE_BITS-1:0]};
      return p[SINE_TABLE_BITS] ? AW'(QUARTER) - r : r;
   endfunction

   always_comb begin
      rounded  = {1'b0, angle} + (ANGLE_W + 1)'(HALF);
      p_sin    = rounded[SHIFT +: PW];
      p_cos    = p_sin + PW'(QUARTER);
      addr_sin = fold(p_sin);
      addr_cos = fold(p_cos);
   end

   always_comb begin
      fill_addr_in = fill_addr_ff;
      fill_done_in = fill_done_ff;
      if (!fill_done_ff) begin
         if (fill_addr_ff == AW'(DEPTH - 1)) begin
            fill_done_in = 1'b1;
         end else begin
            fill_addr_in = fill_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_addr_ff <= '0;
         fill_done_ff <= 1'b0;
      end else begin
         fill_addr_ff <= fill_addr_in;
         fill_done_ff <= fill_done_in;
      end
      if (lookup_en) begin
         sin_neg_ff <= p_sin[PW-1];
         cos_neg_ff <= p_cos[PW-1];
      end
   end

   psv_ram #(
      .WIDTH (MAG_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (!fill_done_ff),
      .wr_addr   (fill_addr_ff),
      .wr_data   (sine_tab[fill_addr_ff]),
      .rd_en     (lookup_en),
      .rd_addr_a (addr_sin),
      .rd_addr_b (addr_cos),
      .rd_data_a (sin_mag),
      .rd_data_b (cos_mag)
   );

   assign trig.sin_mag = sin_mag;
   assign trig.sin_neg = sin_neg_ff;
   assign trig.cos_mag = cos_mag;
   assign trig.cos_neg = cos_neg_ff;
   assign table_ready  = fill_done_ff;

endmodule

// ===== hw/rtl/psv_sequencer.sv =====
// ---------------------------------------------------------------------------
// psv_sequencer: walks one slice and issues one vertex descriptor a step
// start vertex, rim indices with optional center, end vertex, optional closing center
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psv_sequencer import psv_pkg::*; #(
   parameter int LINE_COUNT = LINE_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         open,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req,
   input  logic         step,
   output logic         desc_valid,
   output vtx_desc_type desc,
   output job_type      job
);

   localparam int IDX_W  = $clog2(2 * LINE_COUNT);
   localparam int JW     = $clog2(LINE_COUNT);
   localparam int PROD_W = 17 + $clog2(LINE_COUNT);

   typedef enum logic [2:0] {
      IDLE,
      START,
      LOOP_RIM,
      LOOP_CTR,
      END_RIM,
      CLOSE
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   ei_ff, ei_in;
   logic               fill_ff, fill_in;
   logic               closing_ff, closing_in;
   logic [ANGLE_W-1:0] sa_ff, sa_in;
   logic [ANGLE_W-1:0] ea_ff, ea_in;
   job_type            job_ff, job_in;

   logic [15:0]        rim_tab [LINE_COUNT];
   logic               accept;
   logic [ANGLE_W-1:0] sa_sat;
   logic [ANGLE_W-1:0] ea_sat;
   logic [PROD_W-1:0]  si_prod;
   logic [PROD_W-1:0]  ei_prod;
   logic [IDX_W-1:0]   si;
   logic [IDX_W-1:0]   ei;
   logic [IDX_W-1:0]   idx_inc;
   logic [JW-1:0]      rim_j;

   // rim angle of index j, the same for j + LINE_COUNT modulo a turn
   for (genvar j = 0; j < LINE_COUNT; j++) begin : g_rim
      assign rim_tab[j] = 16'((j * 65536 + LINE_COUNT / 2) / LINE_COUNT);
   end

   assign req_ready = (state_ff == IDLE) && open;
   assign accept    = req_valid && req_ready;

   always_comb begin
      sa_sat  = (req.start_angle > FULL_TURN) ? FULL_TURN : req.start_angle;
      ea_sat  = (req.end_angle > FULL_TURN) ? FULL_TURN : req.end_angle;
      // nearest segment index, half a segment rounds up
      si_prod = PROD_W'(sa_sat) * PROD_W'(LINE_COUNT) + PROD_W'(32768);
      ei_prod = PROD_W'(ea_sat) * PROD_W'(LINE_COUNT) + PROD_W'(32768);
      si      = IDX_W'(si_prod >> 16);
      ei      = IDX_W'(ei_prod >> 16);
      idx_inc = idx_ff + IDX_W'(1);
      rim_j   = (idx_ff >= IDX_W'(LINE_COUNT)) ? JW'(idx_ff - IDX_W'(LINE_COUNT))
                                               : JW'(idx_ff);
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      ei_in      = ei_ff;
      fill_in    = fill_ff;
      closing_in = closing_ff;
      sa_in      = sa_ff;
      ea_in      = ea_ff;
      job_in     = job_ff;
      if (accept) begin
         state_in        = START;
         idx_in          = si;
         ei_in           = (ei < si) ? ei + IDX_W'(LINE_COUNT) : ei;
         fill_in         = req.fill_on;
         // span is below a full turn unless it is exactly zero to a full turn
         closing_in      = !((sa_sat == '0) && (ea_sat == FULL_TURN));
         sa_in           = sa_sat;
         ea_in           = ea_sat;
         job_in.center_x = req.center_x;
         job_in.center_y = req.center_y;
         job_in.radius   = req.radius;
      end else if (step) begin
         unique case (state_ff)
            IDLE: begin
               state_in = IDLE;
            end
            START: begin
               state_in = (idx_ff < ei_ff) ? LOOP_RIM : END_RIM;
            end
            LOOP_RIM: begin
               idx_in = idx_inc;
               if (fill_ff) begin
                  state_in = LOOP_CTR;
               end else begin
                  state_in = (idx_inc < ei_ff) ? LOOP_RIM : END_RIM;
               end
            end
            LOOP_CTR: begin
               state_in = (idx_ff < ei_ff) ? LOOP_RIM : END_RIM;
            end
            END_RIM: begin
               state_in = closing_ff ? CLOSE : IDLE;
            end
            CLOSE: begin
               state_in = IDLE;
            end
            default: begin
               state_in = IDLE;
            end
         endcase
      end
   end

   always_comb begin
      desc_valid  = 1'b1;
      desc.center = 1'b0;
      desc.last   = 1'b0;
      desc.angle  = '0;
      unique case (state_ff)
         IDLE: begin
            desc_valid = 1'b0;
         end
         START: begin
            desc.angle = sa_ff;
         end
         LOOP_RIM: begin
            desc.angle = {1'b0, rim_tab[rim_j]};
         end
         LOOP_CTR: begin
            desc.center = 1'b1;
         end
         END_RIM: begin
            desc.angle = ea_ff;
            desc.last  = !closing_ff;
         end
         CLOSE: begin
            desc.center = 1'b1;
            desc.last   = 1'b1;
         end
         default: begin
            desc_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff     <= idx_in;
      ei_ff      <= ei_in;
      fill_ff    <= fill_in;
      closing_ff <= closing_in;
      sa_ff      <= sa_in;
      ea_ff      <= ea_in;
      job_ff     <= job_in;
   end

   assign job = job_ff;

   `PSV_ASSERT_IMP(a_rim_in_range, state_ff == LOOP_RIM, idx_ff < ei_ff)
   `PSV_ASSERT_IMP(a_ctr_needs_fill, state_ff == LOOP_CTR, fill_ff)
   `PSV_ASSERT_NXT(a_accept_starts, accept, state_ff == START)

endmodule
